### sv/rgb_to_ycbcr422_packer_assert.svh
// assertion macros shared by the ycbcr 4:2:2 packer checker
`ifndef RGB_TO_YCBCR422_PACKER_ASSERT_SVH
`define RGB_TO_YCBCR422_PACKER_ASSERT_SVH

// same-cycle implication, masked while reset is low
`define YCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is low
`define YCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define YCC_ASSERT_NXT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ycc422_pkg.sv
// shared types and constants for the ycbcr 4:2:2 packer
package ycc422_pkg;

  localparam int unsigned MAX_DIMENSION = 8192;
  localparam int unsigned DIM_W = 14;  // register and dimension width
  localparam int unsigned CNT_W = 13;  // column / row counter width
  localparam int unsigned SUM_W = 26;  // signed q16 accumulator width
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_DIMENSION);
  localparam logic [DIM_W-1:0] LINE_WIDTH_RST = 14'd1920;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 14'd1080;

  // q16 coefficients, round(c * 65536)
  localparam logic signed [SUM_W-1:0] Y_R = 26'sd19595;
  localparam logic signed [SUM_W-1:0] Y_G = 26'sd38470;
  localparam logic signed [SUM_W-1:0] Y_B = 26'sd7471;
  localparam logic signed [SUM_W-1:0] CB_R = 26'sd11076;
  localparam logic signed [SUM_W-1:0] CB_G = 26'sd21692;
  localparam logic signed [SUM_W-1:0] CB_B = 26'sd32768;
  localparam logic signed [SUM_W-1:0] CR_R = 26'sd32768;
  localparam logic signed [SUM_W-1:0] CR_G = 26'sd27460;
  localparam logic signed [SUM_W-1:0] CR_B = 26'sd5308;
  localparam logic signed [SUM_W-1:0] OFFSET_Q16 = 26'sd8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic is_cr;
    logic eol;
    logic eof;
  } pos_flags_t;

endpackage

### sv/rgb_to_ycbcr422_packer.sv
// ycbcr 4:2:2 packer top level: position tracking, input and result registers
// Takes one 8-bit rgb pixel per item in raster order and gives one item per
// pixel with its luma and one chroma byte: cb on even columns, cr on odd
// columns of each line (picked, not averaged), plus end-of-line and
// end-of-frame flags derived from line_width and frame_height. A register
// value of 0 acts as 1 and values above 8192 act as 8192. The block takes one
// item per clock while out_ready is high; each item passes the input
// register (where its column/row position is stamped) and then the result
// register (fed by the constant-coefficient multiply-add and clamp). in_ready
// follows out_ready through both stages, so a full pipe stalled downstream
// holds two items. Config writes go straight to the registers and leave the
// column and row counters alone; a width shrunk below the current column ends
// its line at the next pixel, a shrunk height the frame at the next line end.
module rgb_to_ycbcr422_packer
  import ycc422_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  // packed result
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_luma,
  output logic [7:0]           out_chroma,
  output logic                 out_chroma_is_cr,
  output logic                 out_end_of_line,
  output logic                 out_end_of_frame,
  // register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  // config registers
  logic [DIM_W-1:0] line_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // raster position of the next pixel
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  pos_flags_t       pos_flags;

  // input stage
  logic       s1_valid_r, s1_valid_nxt;
  pix_t       s1_pix_r;
  pos_flags_t s1_flags_r;

  // result stage
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] luma_r;
  logic [7:0] chroma_r;
  pos_flags_t out_flags_r;

  logic [7:0] luma_c;
  logic [7:0] chroma_c;
  logic       in_fire;
  logic       s2_load;

  // register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINE_WIDTH:   line_width_r   <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the max
  always_comb begin
    if (line_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (line_width_r > MAX_DIM) begin
      w_eff = MAX_DIM;
    end else begin
      w_eff = line_width_r;
    end
    if (frame_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (frame_height_r > MAX_DIM) begin
      h_eff = MAX_DIM;
    end else begin
      h_eff = frame_height_r;
    end
  end

  // pipeline flow: result slot frees when empty or taken, input slot when
  // empty or moving on
  assign s2_load  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_load;
  assign in_fire  = in_valid && in_ready;

  // position flags of the pixel being accepted; >= covers a shrunk register
  always_comb begin
    pos_flags.is_cr = col_r[0];
    pos_flags.eol   = ({1'b0, col_r} + DIM_W'(1)) >= w_eff;
    pos_flags.eof   = pos_flags.eol && (({1'b0, row_r} + DIM_W'(1)) >= h_eff);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (pos_flags.eol) begin
        col_nxt = '0;
        row_nxt = pos_flags.eof ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // input register
  assign s1_valid_nxt = in_fire ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= '{red: in_red, green: in_green, blue: in_blue};
      s1_flags_r <= pos_flags;
    end
  end

  ycc422_csc u_csc (
    .pix    (s1_pix_r),
    .is_cr  (s1_flags_r.is_cr),
    .luma   (luma_c),
    .chroma (chroma_c)
  );

  // result register
  assign out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      luma_r      <= luma_c;
      chroma_r    <= chroma_c;
      out_flags_r <= s1_flags_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = luma_r;
  assign out_chroma       = chroma_r;
  assign out_chroma_is_cr = out_flags_r.is_cr;
  assign out_end_of_line  = out_flags_r.eol;
  assign out_end_of_frame = out_flags_r.eof;

endmodule

### sv/ycc422_csc.sv
// rgb to y and picked chroma (cb or cr) color space math
module ycc422_csc
  import ycc422_pkg::*;
(
  input  pix_t       pix,
  input  logic       is_cr,
  output logic [7:0] luma,
  output logic [7:0] chroma
);

  logic signed [SUM_W-1:0] r_s;
  logic signed [SUM_W-1:0] g_s;
  logic signed [SUM_W-1:0] b_s;
  logic signed [SUM_W-1:0] y_sum;
  logic signed [SUM_W-1:0] cb_sum;
  logic signed [SUM_W-1:0] cr_sum;

  // truncate q16 toward zero and clamp to 0..255
  function automatic logic [7:0] q16_to_byte(input logic signed [SUM_W-1:0] s);
    logic [7:0] res;
    if (s[SUM_W-1]) begin
      res = 8'd0;
    end else if (s[SUM_W-2]) begin
      res = 8'hff;
    end else begin
      res = s[23:16];
    end
    return res;
  endfunction

  assign r_s = $signed({{(SUM_W-8){1'b0}}, pix.red});
  assign g_s = $signed({{(SUM_W-8){1'b0}}, pix.green});
  assign b_s = $signed({{(SUM_W-8){1'b0}}, pix.blue});

  // constant multiplies only
  assign y_sum  = Y_R * r_s + Y_G * g_s + Y_B * b_s;
  assign cb_sum = OFFSET_Q16 - CB_R * r_s - CB_G * g_s + CB_B * b_s;
  assign cr_sum = OFFSET_Q16 + CR_R * r_s - CR_G * g_s - CR_B * b_s;

  assign luma   = q16_to_byte(y_sum);
  assign chroma = is_cr ? q16_to_byte(cr_sum) : q16_to_byte(cb_sum);

endmodule

### sv/ycc422_checker.sv
// port-level checker for the ycbcr 4:2:2 packer, bound to the top level
`include "rgb_to_ycbcr422_packer_assert.svh"

module ycc422_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_luma,
  input logic [7:0] out_chroma,
  input logic       out_chroma_is_cr,
  input logic       out_end_of_line,
  input logic       out_end_of_frame
);

  // result offered but not taken this cycle
  logic        stalled;
  // every result field in one vector
  logic [18:0] payload;

  assign stalled = out_valid && !out_ready;
  assign payload = {out_luma, out_chroma, out_chroma_is_cr, out_end_of_line,
                    out_end_of_frame};

  // reset empties the result register
  `YCC_ASSERT_NXT_RST(a_rst_empty, clk, !rst_n, !out_valid, "out_valid high after reset")
  // a stalled item stays offered
  `YCC_ASSERT_NXT(a_stall_hold, clk, rst_n, stalled, out_valid, "item dropped")
  // a stalled item keeps its payload
  `YCC_ASSERT_NXT(a_stall_data, clk, rst_n, stalled, $stable(payload), "payload changed")
  // frame end only falls on a line end
  `YCC_ASSERT_IMP(a_eof_eol, clk, rst_n, out_valid && out_end_of_frame, out_end_of_line, "eof without eol")

endmodule

bind rgb_to_ycbcr422_packer ycc422_checker u_ycc422_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_luma         (out_luma),
  .out_chroma       (out_chroma),
  .out_chroma_is_cr (out_chroma_is_cr),
  .out_end_of_line  (out_end_of_line),
  .out_end_of_frame (out_end_of_frame)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the rgb to ycbcr 4:2:2 packer
module tb_top
  import ycc422_pkg::*;
();

  // q16 weights of the conversion, round(c * 65536)
  localparam int LUMA_R = 19595;
  localparam int LUMA_G = 38470;
  localparam int LUMA_B = 7471;
  localparam int BLUE_DIFF_R = 11076;
  localparam int BLUE_DIFF_G = 21692;
  localparam int BLUE_DIFF_B = 32768;
  localparam int RED_DIFF_R = 32768;
  localparam int RED_DIFF_G = 27460;
  localparam int RED_DIFF_B = 5308;
  localparam int CHROMA_BIAS = 128 << 16;

  localparam int RANDOM_ITEMS = 1730;
  // two register stages inside, so a few spare cycles cover any item in flight
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma;
    logic       is_cr;
    logic       eol;
    logic       eof;
  } ycc_result_t;

  typedef enum logic {
    ROW_PIXEL,
    ROW_WRITE
  } row_kind_t;

  // one line of the directed table: either a register write or a pixel,
  // with a hand-computed result where typed is set
  typedef struct packed {
    row_kind_t        kind;
    cfg_idx_t         index;
    logic [DIM_W-1:0] data;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             typed;
    logic [7:0]       luma;
    logic [7:0]       chroma;
    logic             is_cr;
    logic             eol;
    logic             eof;
  } directed_row_t;

  localparam int NUM_DIRECTED = 30;

  // the first rows run with the reset sizes (1920 x 1080), so no line end
  // can show up and the colors alone decide the bytes
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // black, even column: luma 0, neutral cb
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd128, 0, 0, 0},
    // white, odd column: full luma, neutral cr
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd255, 8'd255, 8'd255, 1'b1,
      8'd255, 8'd128, 1, 0, 0},
    // pure red on cb
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd255, 8'd0, 8'd0, 1'b1, 8'd76, 8'd84, 0, 0, 0},
    // pure blue on cr
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd0, 8'd255, 1'b1, 8'd29, 8'd107, 1, 0, 0},
    // pure blue on cb: the largest chroma sum
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd0, 8'd255, 1'b1, 8'd29, 8'd255, 0, 0, 0},
    // width shrunk below the current column: next pixel ends the line
    '{ROW_WRITE, CFG_LINE_WIDTH, 14'd3, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    // zero height acts as one line, row already past it; odd width ends on cb
    '{ROW_WRITE, CFG_FRAME_HEIGHT, 14'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd128, 8'd64, 8'd32, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd17, 8'd200, 8'd99, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd255, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    // zero width acts as one pixel per line
    '{ROW_WRITE, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd255, 8'd0, 8'd255, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    // all-ones registers act as the maximum dimension
    '{ROW_WRITE, CFG_LINE_WIDTH, 14'h3fff, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_WRITE, CFG_FRAME_HEIGHT, 14'h3fff, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd1, 8'd2, 8'd3, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd254, 8'd253, 8'd252, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd85, 8'd170, 8'd85, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    // single-pixel lines in a frame of exactly the maximum height
    '{ROW_WRITE, CFG_LINE_WIDTH, 14'd1, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_WRITE, CFG_FRAME_HEIGHT, 14'd8192, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd170, 8'd85, 8'd170, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    // a tiny 2 x 2 frame, shrinking height below the current row
    '{ROW_WRITE, CFG_LINE_WIDTH, 14'd2, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_WRITE, CFG_FRAME_HEIGHT, 14'd2, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 0, 0, 0},
    '{ROW_PIXEL, CFG_LINE_WIDTH, 14'd0, 8'd0, 8'd0, 8'd255, 1'b0, 8'd0, 8'd0, 0, 0, 0}
  };

  // every input of the block has a known value from time zero
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_red = '0;
  logic [7:0]       in_green = '0;
  logic [7:0]       in_blue = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_luma;
  logic [7:0]       out_chroma;
  logic             out_chroma_is_cr;
  logic             out_end_of_line;
  logic             out_end_of_frame;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = CFG_LINE_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  // the hand-computed result that travels with the item being offered
  logic             typed_pending = 1'b0;
  ycc_result_t      typed_result = '0;

  // predictor copy of the block's registers and position counters
  logic [DIM_W-1:0] shadow_width = LINE_WIDTH_RST;
  logic [DIM_W-1:0] shadow_height = FRAME_HEIGHT_RST;
  int unsigned      pixel_column = 0;
  int unsigned      pixel_row = 0;

  ycc_result_t      expected_pixels [$];
  int               error_count = 0;

  // idle and stall bookkeeping for the two sides
  int               in_calm = 0;
  int               out_calm = 0;
  int               out_stall = 0;

  rgb_to_ycbcr422_packer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_luma         (out_luma),
    .out_chroma       (out_chroma),
    .out_chroma_is_cr (out_chroma_is_cr),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

  // signed q16 sum to a byte: negatives go to zero, the fraction is dropped
  function automatic logic [7:0] q16_to_byte(input int sum);
    if (sum < 0) begin
      return 8'd0;
    end
    if ((sum >>> 16) > 255) begin
      return 8'd255;
    end
    return 8'(sum >>> 16);
  endfunction

  // zero acts as one, anything past the maximum acts as the maximum
  function automatic int unsigned clip_dim(input logic [DIM_W-1:0] value);
    if (value == '0) begin
      return 1;
    end
    if (value > MAX_DIMENSION) begin
      return MAX_DIMENSION;
    end
    return 32'(value);
  endfunction

  // converts one pixel at the current raster position and advances it
  function automatic ycc_result_t convert_pixel(input logic [7:0] r, g, b);
    ycc_result_t res;
    int          ri;
    int          gi;
    int          bi;
    int unsigned w;
    int unsigned h;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    w = clip_dim(shadow_width);
    h = clip_dim(shadow_height);
    res.is_cr = pixel_column[0];
    // a counter at or past the last position also counts as the end
    res.eol = (pixel_column + 1 >= w);
    res.eof = res.eol && (pixel_row + 1 >= h);
    res.luma = q16_to_byte(LUMA_R * ri + LUMA_G * gi + LUMA_B * bi);
    if (res.is_cr) begin
      res.chroma = q16_to_byte(RED_DIFF_R * ri - RED_DIFF_G * gi - RED_DIFF_B * bi
                               + CHROMA_BIAS);
    end else begin
      res.chroma = q16_to_byte(BLUE_DIFF_B * bi - BLUE_DIFF_R * ri - BLUE_DIFF_G * gi
                               + CHROMA_BIAS);
    end
    if (res.eol) begin
      pixel_column = 0;
      pixel_row = res.eof ? 0 : pixel_row + 1;
    end else begin
      pixel_column = pixel_column + 1;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // input gaps: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap();
    int pick;
    if (in_calm > 0) begin
      in_calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      in_calm = $urandom_range(20, 100);
    end
    if (pick < 60) begin
      return 0;
    end
    if (pick < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // color channel that lands on the extremes now and then
  function automatic logic [7:0] random_channel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return 8'd0;
    end
    if (pick == 1) begin
      return 8'd255;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // register value: mostly small frames so line and frame ends come often
  function automatic logic [DIM_W-1:0] random_dim(input int small_max);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return DIM_W'($urandom_range(1, small_max));
    end
    if (pick < 78) begin
      return DIM_W'($urandom_range(17, 80));
    end
    if (pick < 84) begin
      return '0;
    end
    if (pick < 89) begin
      return MAX_DIM;
    end
    if (pick < 94) begin
      return DIM_W'($urandom_range(MAX_DIMENSION + 1, 16383));
    end
    return DIM_W'($urandom_range(0, 16383));
  endfunction

  // offers one item and returns at the edge where it is taken
  task automatic send_pixel(input logic [7:0] r, g, b, input logic typed,
                            input ycc_result_t typed_value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_red        <= r;
    in_green      <= g;
    in_blue       <= b;
    typed_pending <= typed;
    typed_result  <= typed_value;
    do @(posedge clk); while (!in_ready);
  endtask

  // stops offering items and waits until every result is back
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // registers only change while the block holds no item
  task automatic write_register(input cfg_idx_t idx, input logic [DIM_W-1:0] value);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LINE_WIDTH) begin
      shadow_width = value;
    end else begin
      shadow_height = value;
    end
  endtask

  // result side: short random stalls, a few long ones, calm stretches
  always @(posedge clk) begin
    int pick;
    if (out_calm > 0) begin
      out_calm--;
      out_ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        out_calm = $urandom_range(20, 120);
      end
      if (pick < 65) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_stall = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
      end
    end
  end

  // every accepted pixel runs through the predictor so its counters stay in
  // step; rows with a hand-computed result queue that one instead
  always @(posedge clk) begin
    ycc_result_t predicted;
    ycc_result_t queued;
    if (rst_n && in_valid && in_ready) begin
      predicted = convert_pixel(in_red, in_green, in_blue);
      queued = typed_pending ? typed_result : predicted;
      expected_pixels = {expected_pixels, queued};
    end
  end

  // each result is matched against the oldest outstanding pixel
  always @(posedge clk) begin
    ycc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        $display("%0t: result with no pixel outstanding, expected none actual luma %0d",
                 $time, out_luma);
      end else begin
        want = expected_pixels.pop_front();
        check_field("luma", want.luma, out_luma);
        check_field("chroma", want.chroma, out_chroma);
        check_field("chroma_is_cr", want.is_cr, out_chroma_is_cr);
        check_field("end_of_line", want.eol, out_end_of_line);
        check_field("end_of_frame", want.eof, out_end_of_frame);
      end
    end
  end

  initial begin
    directed_row_t row;
    int            sent;
    int            phase_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        write_register(row.index, row.data);
      end else begin
        send_pixel(row.red, row.green, row.blue, row.typed,
                   ycc_result_t'({row.luma, row.chroma, row.is_cr, row.eol, row.eof}));
      end
    end

    // random phases: new frame sizes between bursts of pixels; counters carry
    // over, so a smaller size often lands below the current position
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        write_register(CFG_LINE_WIDTH, random_dim(16));
      end
      if ($urandom_range(0, 99) < 85) begin
        write_register(CFG_FRAME_HEIGHT, random_dim(6));
      end
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        send_pixel(random_channel(), random_channel(), random_channel(), 1'b0, '0);
        sent++;
      end
    end

    drain_pipeline();
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
